// ===== rtl/scs_pkg.sv =====
// ============================================================================
// scs_pkg - shared definitions for the single-cycle CPU subset
// Widths, instruction opcodes and function codes, item modes.
// ============================================================================
`default_nettype none

package scs_pkg;

    // datapath widths
    localparam int XLEN     = 32;
    localparam int REG_W    = 5;
    localparam int NUM_REGS = 32;
    localparam int MODE_W   = 2;
    localparam int WADDR_W  = 30;   // byte address without its low two bits

    // default data memory depth in words
    localparam int DATA_WORDS_DEF = 32;

    // item modes
    typedef enum logic [MODE_W-1:0] {
        MODE_EXEC    = 2'd0,
        MODE_PRE_REG = 2'd1,
        MODE_PRE_MEM = 2'd2
    } mode_t;

    // primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_J     = 6'b000010;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_SW    = 6'b101011;

    // R-type function codes
    localparam logic [5:0] FN_ADD = 6'b100000;
    localparam logic [5:0] FN_SUB = 6'b100010;
    localparam logic [5:0] FN_AND = 6'b100100;
    localparam logic [5:0] FN_OR  = 6'b100101;
    localparam logic [5:0] FN_NOR = 6'b100111;
    localparam logic [5:0] FN_SLT = 6'b101010;

endpackage

`default_nettype wire

// ===== rtl/scs_item_if.sv =====
// ============================================================================
// scs_item_if - input channel of the CPU subset
// Valid/ready channel carrying one instruction or preload request per beat.
// ============================================================================
`default_nettype none

interface scs_item_if;
    import scs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [XLEN-1:0]          instr_word;
    logic [REG_W-1:0]         preload_index;
    logic signed [XLEN-1:0]   preload_value;

    modport source (
        output valid, mode, instr_word, preload_index, preload_value,
        input  ready
    );

    modport sink (
        input  valid, mode, instr_word, preload_index, preload_value,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/scs_result_if.sv =====
// ============================================================================
// scs_result_if - result channel of the CPU subset
// Valid/ready channel carrying one execution report per beat.
// ============================================================================
`default_nettype none

interface scs_result_if;
    import scs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [XLEN-1:0]          next_pc;
    logic                     reg_written;
    logic [REG_W-1:0]         reg_number;
    logic signed [XLEN-1:0]   reg_result;
    logic                     mem_written;
    logic [XLEN-1:0]          mem_address;
    logic signed [XLEN-1:0]   mem_data;
    logic                     branch_taken;
    logic [XLEN-1:0]          instr_count;

    modport source (
        output valid, next_pc, reg_written, reg_number, reg_result, mem_written,
               mem_address, mem_data, branch_taken, instr_count,
        input  ready
    );

    modport sink (
        input  valid, next_pc, reg_written, reg_number, reg_result, mem_written,
               mem_address, mem_data, branch_taken, instr_count,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/scs_word_mod.sv =====
// ============================================================================
// scs_word_mod - word address to data memory index
// Two-stage reduction of a word address modulo DATA_WORDS: reciprocal
// multiply for the quotient, then multiply-back and subtract.
// ============================================================================
`default_nettype none

module scs_word_mod #(
    parameter int DATA_WORDS = scs_pkg::DATA_WORDS_DEF
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [scs_pkg::WADDR_W-1:0]     word_addr,
    output logic [$clog2(DATA_WORDS)-1:0]   word_idx
);
    import scs_pkg::*;

    // exact reciprocal for every WADDR_W-bit dividend
    localparam int IDX_W   = $clog2(DATA_WORDS);
    localparam int SHIFT   = WADDR_W + IDX_W;
    localparam int RECIP_W = WADDR_W + 1;
    localparam int PROD_W  = WADDR_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DATA_WORDS) - 64'd1) / 64'(DATA_WORDS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  prod_sh;
    logic [WADDR_W-1:0] quot_next;
    logic [WADDR_W-1:0] quot_reg;
    logic [WADDR_W-1:0] addr_d_reg;
    logic [WADDR_W-1:0] quot_mul;
    logic [WADDR_W-1:0] rem;
    logic [IDX_W-1:0]   idx_reg;

    // stage 1: quotient by reciprocal
    assign prod      = PROD_W'(word_addr) * PROD_W'(RECIP);
    assign prod_sh   = prod >> SHIFT;
    assign quot_next = prod_sh[WADDR_W-1:0];

    // stage 2: remainder, always below DATA_WORDS
    assign quot_mul = quot_reg * WADDR_W'(DATA_WORDS);
    assign rem      = addr_d_reg - quot_mul;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg   <= quot_next;
            addr_d_reg <= word_addr;
            idx_reg    <= rem[IDX_W-1:0];
        end
    end

    assign word_idx = idx_reg;

endmodule

`default_nettype wire

// ===== rtl/single_cycle_cpu_subset.sv =====
// ============================================================================
// single_cycle_cpu_subset - top level of the CPU subset
// Executes add/sub/and/or/slt/nor, lw, sw, beq and j, or preloads a register
// or data word, one item per beat, and reports the effect of each item.
// ============================================================================
// Sustained rate is one item per clock when no load-use hold, back-pressure or
// sweep stalls it. A result passes execute, two address-reduction stages, data
// memory access and writeback before the output register; the register file
// operands are read on the accepting edge. An instruction that reads the target
// of a lw among the three items before it waits until the load reaches
// writeback, where its data sits in the data memory read register. After reset
// the register file and data memory are swept to zero with item.ready low.
// While a finished result waits in the output register every stage holds; at
// most one more item enters, into the execute register.
`default_nettype none

module single_cycle_cpu_subset #(
    parameter int DATA_WORDS = scs_pkg::DATA_WORDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    scs_item_if.sink      item,
    scs_result_if.source  result
);
    import scs_pkg::*;

    localparam int IDX_W     = $clog2(DATA_WORDS);
    localparam int CLR_WORDS = (DATA_WORDS > NUM_REGS) ? DATA_WORDS : NUM_REGS;
    localparam int CLR_W     = $clog2(CLR_WORDS);
    localparam int NSTG      = 4;           // stages after execute
    localparam int ST_MEM    = 2;           // data memory access stage
    localparam int ST_WB     = NSTG - 1;    // writeback stage

    typedef struct packed {
        logic               rf_we;
        logic [REG_W-1:0]   rf_waddr;
        logic               is_load;
        logic [XLEN-1:0]    rf_wdata;
        logic               rep_reg;
        logic               dm_we;
        logic               dm_re;
        logic [XLEN-1:0]    dm_wdata;
        logic [WADDR_W-1:0] word_addr;
        logic               rep_mem;
        logic [XLEN-1:0]    mem_address;
        logic               branch;
        logic [XLEN-1:0]    next_pc;
        logic [XLEN-1:0]    count;
    } stage_t;

    // storage
    logic [XLEN-1:0] rf_mem [NUM_REGS];
    logic [XLEN-1:0] dmem   [DATA_WORDS];

    // clearing sweep
    logic             clr_busy_reg;
    logic [CLR_W-1:0] clr_idx_reg;
    logic             clr_dm_en;

    // execute stage
    logic               s1_vld_reg;
    logic [MODE_W-1:0]  s1_mode_reg;
    logic [XLEN-1:0]    s1_iw_reg;
    logic [REG_W-1:0]   s1_pidx_reg;
    logic [XLEN-1:0]    s1_pval_reg;
    logic [XLEN-1:0]    rd_a_reg;
    logic [XLEN-1:0]    rd_b_reg;
    logic               byp_a_vld_reg;
    logic               byp_b_vld_reg;
    logic [XLEN-1:0]    byp_a_reg;
    logic [XLEN-1:0]    byp_b_reg;
    logic [XLEN-1:0]    pc_reg;
    logic [XLEN-1:0]    pc_next;
    logic [XLEN-1:0]    cnt_reg;
    logic [XLEN-1:0]    cnt_next;

    logic [5:0]         op;
    logic [REG_W-1:0]   s1_rs;
    logic [REG_W-1:0]   s1_rt;
    logic [REG_W-1:0]   s1_rd;
    logic [5:0]         fn;
    logic [XLEN-1:0]    sext;
    logic [XLEN-1:0]    seq_pc;
    logic [XLEN-1:0]    opa;
    logic [XLEN-1:0]    opb;
    logic               pend_a;
    logic               pend_b;
    logic [XLEN-1:0]    alu_res;
    logic               alu_ok;
    logic [XLEN-1:0]    mem_addr;
    stage_t             stg_next;

    // handshake and pipeline control
    logic               item_acc;
    logic               pipe_en;
    logic               hazard;
    logic               s1_move;
    logic               hit_a_in;
    logic               hit_b_in;

    // back stages
    logic [NSTG-1:0]    st_vld_reg;
    stage_t             st_reg [NSTG];
    logic [IDX_W-1:0]   dm_idx;
    logic               dm_wr_en;
    logic               dm_rd_en;
    logic [XLEN-1:0]    dmem_q_reg;
    logic               wb_en;
    logic [REG_W-1:0]   wb_addr;
    logic [XLEN-1:0]    wb_data;

    // output register
    logic               out_vld_reg;
    logic [XLEN-1:0]    out_pc_reg;
    logic               out_rwr_reg;
    logic [REG_W-1:0]   out_rnum_reg;
    logic [XLEN-1:0]    out_rres_reg;
    logic               out_mwr_reg;
    logic [XLEN-1:0]    out_maddr_reg;
    logic [XLEN-1:0]    out_mdata_reg;
    logic               out_br_reg;
    logic [XLEN-1:0]    out_cnt_reg;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign pipe_en    = !out_vld_reg || result.ready;
    assign hazard     = s1_vld_reg && (s1_mode_reg == MODE_EXEC) && (pend_a || pend_b);
    assign s1_move    = s1_vld_reg && pipe_en && !hazard;
    assign item.ready = !clr_busy_reg && (!s1_vld_reg || s1_move);
    assign item_acc   = item.valid && item.ready;

    // ------------------------------------------------------------------
    // clearing sweep after reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == CLR_W'(CLR_WORDS - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    assign clr_dm_en = ({1'b0, clr_idx_reg} < (CLR_W + 1)'(DATA_WORDS));

    // ------------------------------------------------------------------
    // register file: two registered reads, one write
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            rf_mem[clr_idx_reg[REG_W-1:0]] <= '0;
        else if (wb_en)
            rf_mem[wb_addr] <= wb_data;
        if (item_acc)
        begin
            rd_a_reg <= rf_mem[item.instr_word[25:21]];
            rd_b_reg <= rf_mem[item.instr_word[20:16]];
        end
    end

    // writeback written on the same edge as the read needs a bypass
    assign hit_a_in = st_vld_reg[ST_WB] && st_reg[ST_WB].rf_we
                      && (st_reg[ST_WB].rf_waddr == item.instr_word[25:21]);
    assign hit_b_in = st_vld_reg[ST_WB] && st_reg[ST_WB].rf_we
                      && (st_reg[ST_WB].rf_waddr == item.instr_word[20:16]);

    // ------------------------------------------------------------------
    // execute stage registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            byp_a_vld_reg <= 1'b0;
            byp_b_vld_reg <= 1'b0;
            pc_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (item_acc)
            begin
                s1_vld_reg    <= 1'b1;
                byp_a_vld_reg <= hit_a_in;
                byp_b_vld_reg <= hit_b_in;
            end
            else if (s1_move)
                s1_vld_reg <= 1'b0;
            else if (s1_vld_reg)
            begin
                // held: keep the resolved operands
                byp_a_vld_reg <= 1'b1;
                byp_b_vld_reg <= 1'b1;
            end
            if (s1_move)
            begin
                pc_reg  <= pc_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            s1_mode_reg <= item.mode;
            s1_iw_reg   <= item.instr_word;
            s1_pidx_reg <= item.preload_index;
            s1_pval_reg <= item.preload_value;
            byp_a_reg   <= wb_data;
            byp_b_reg   <= wb_data;
        end
        else if (s1_vld_reg && !s1_move)
        begin
            byp_a_reg <= opa;
            byp_b_reg <= opb;
        end
    end

    // instruction fields
    assign op     = s1_iw_reg[31:26];
    assign s1_rs  = s1_iw_reg[25:21];
    assign s1_rt  = s1_iw_reg[20:16];
    assign s1_rd  = s1_iw_reg[15:11];
    assign fn     = s1_iw_reg[5:0];
    assign sext   = {{(XLEN-16){s1_iw_reg[15]}}, s1_iw_reg[15:0]};
    assign seq_pc = pc_reg + XLEN'(4);

    // operand forwarding, newest producer wins; loads resolve at writeback
    always_comb
    begin
        opa    = byp_a_vld_reg ? byp_a_reg : rd_a_reg;
        opb    = byp_b_vld_reg ? byp_b_reg : rd_b_reg;
        pend_a = 1'b0;
        pend_b = 1'b0;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            if (st_vld_reg[i] && st_reg[i].rf_we && (st_reg[i].rf_waddr == s1_rs))
            begin
                if (!st_reg[i].is_load)
                begin
                    opa    = st_reg[i].rf_wdata;
                    pend_a = 1'b0;
                end
                else if (i == ST_WB)
                begin
                    opa    = dmem_q_reg;
                    pend_a = 1'b0;
                end
                else
                    pend_a = 1'b1;
            end
            if (st_vld_reg[i] && st_reg[i].rf_we && (st_reg[i].rf_waddr == s1_rt))
            begin
                if (!st_reg[i].is_load)
                begin
                    opb    = st_reg[i].rf_wdata;
                    pend_b = 1'b0;
                end
                else if (i == ST_WB)
                begin
                    opb    = dmem_q_reg;
                    pend_b = 1'b0;
                end
                else
                    pend_b = 1'b1;
            end
        end
    end

    // ALU for R-type
    always_comb
    begin
        alu_ok = 1'b1;
        unique case (fn)
            FN_ADD:  alu_res = opa + opb;
            FN_SUB:  alu_res = opa - opb;
            FN_AND:  alu_res = opa & opb;
            FN_OR:   alu_res = opa | opb;
            FN_NOR:  alu_res = ~(opa | opb);
            FN_SLT:  alu_res = {{(XLEN-1){1'b0}}, ($signed(opa) < $signed(opb))};
            default:
            begin
                alu_res = '0;
                alu_ok  = 1'b0;
            end
        endcase
    end

    assign mem_addr = opa + sext;

    // item decode into the stage record, PC and count update
    always_comb
    begin
        stg_next         = '0;
        stg_next.next_pc = pc_reg;
        stg_next.count   = cnt_reg;
        pc_next          = pc_reg;
        cnt_next         = cnt_reg;
        unique case (s1_mode_reg)
            MODE_EXEC:
            begin
                cnt_next = cnt_reg + 1'b1;
                pc_next  = seq_pc;
                unique case (op)
                    OP_RTYPE:
                    begin
                        if (alu_ok && (s1_rd != '0))
                        begin
                            stg_next.rf_we    = 1'b1;
                            stg_next.rep_reg  = 1'b1;
                            stg_next.rf_waddr = s1_rd;
                            stg_next.rf_wdata = alu_res;
                        end
                    end
                    OP_LW:
                    begin
                        stg_next.dm_re       = 1'b1;
                        stg_next.word_addr   = mem_addr[XLEN-1:2];
                        stg_next.mem_address = mem_addr;
                        if (s1_rt != '0)
                        begin
                            stg_next.rf_we    = 1'b1;
                            stg_next.rep_reg  = 1'b1;
                            stg_next.is_load  = 1'b1;
                            stg_next.rf_waddr = s1_rt;
                        end
                    end
                    OP_SW:
                    begin
                        stg_next.dm_we       = 1'b1;
                        stg_next.rep_mem     = 1'b1;
                        stg_next.word_addr   = mem_addr[XLEN-1:2];
                        stg_next.mem_address = mem_addr;
                        stg_next.dm_wdata    = opb;
                    end
                    OP_BEQ:
                    begin
                        if (opa == opb)
                        begin
                            pc_next         = seq_pc + {sext[XLEN-3:0], 2'b00};
                            stg_next.branch = 1'b1;
                        end
                    end
                    OP_J:
                    begin
                        pc_next         = {seq_pc[XLEN-1:28], s1_iw_reg[25:0], 2'b00};
                        stg_next.branch = 1'b1;
                    end
                    default: ;
                endcase
                stg_next.next_pc = pc_next;
                stg_next.count   = cnt_next;
            end
            MODE_PRE_REG:
            begin
                if (s1_pidx_reg != '0)
                begin
                    stg_next.rf_we    = 1'b1;
                    stg_next.rf_waddr = s1_pidx_reg;
                    stg_next.rf_wdata = s1_pval_reg;
                end
            end
            MODE_PRE_MEM:
            begin
                stg_next.dm_we     = 1'b1;
                stg_next.word_addr = WADDR_W'(s1_pidx_reg);
                stg_next.dm_wdata  = s1_pval_reg;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // back stages: address reduction, memory access, writeback
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_vld_reg <= '0;
        else if (pipe_en)
            st_vld_reg <= {st_vld_reg[NSTG-2:0], s1_move};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            st_reg[0] <= stg_next;
            for (int i = 1; i < NSTG; i++)
                st_reg[i] <= st_reg[i-1];
        end
    end

    scs_word_mod #(
        .DATA_WORDS (DATA_WORDS)
    ) u_word_mod (
        .clk       (clk),
        .en        (pipe_en),
        .word_addr (st_reg[0].word_addr),
        .word_idx  (dm_idx)
    );

    // data memory: one write, one registered read
    assign dm_wr_en = pipe_en && st_vld_reg[ST_MEM] && st_reg[ST_MEM].dm_we;
    assign dm_rd_en = pipe_en && st_vld_reg[ST_MEM] && st_reg[ST_MEM].dm_re;

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            if (clr_dm_en)
                dmem[clr_idx_reg[IDX_W-1:0]] <= '0;
        end
        else if (dm_wr_en)
            dmem[dm_idx] <= st_reg[ST_MEM].dm_wdata;
        if (dm_rd_en)
            dmem_q_reg <= dmem[dm_idx];
    end

    // register writeback
    assign wb_en   = pipe_en && st_vld_reg[ST_WB] && st_reg[ST_WB].rf_we;
    assign wb_addr = st_reg[ST_WB].rf_waddr;
    assign wb_data = st_reg[ST_WB].is_load ? dmem_q_reg : st_reg[ST_WB].rf_wdata;

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (pipe_en)
            out_vld_reg <= st_vld_reg[ST_WB];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && st_vld_reg[ST_WB])
        begin
            out_pc_reg    <= st_reg[ST_WB].next_pc;
            out_rwr_reg   <= st_reg[ST_WB].rep_reg;
            out_rnum_reg  <= st_reg[ST_WB].rep_reg ? wb_addr : '0;
            out_rres_reg  <= st_reg[ST_WB].rep_reg ? wb_data : '0;
            out_mwr_reg   <= st_reg[ST_WB].rep_mem;
            out_maddr_reg <= st_reg[ST_WB].mem_address;
            out_mdata_reg <= st_reg[ST_WB].rep_mem ? st_reg[ST_WB].dm_wdata : '0;
            out_br_reg    <= st_reg[ST_WB].branch;
            out_cnt_reg   <= st_reg[ST_WB].count;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.next_pc      = out_pc_reg;
    assign result.reg_written  = out_rwr_reg;
    assign result.reg_number   = out_rnum_reg;
    assign result.reg_result   = out_rres_reg;
    assign result.mem_written  = out_mwr_reg;
    assign result.mem_address  = out_maddr_reg;
    assign result.mem_data     = out_mdata_reg;
    assign result.branch_taken = out_br_reg;
    assign result.instr_count  = out_cnt_reg;

`ifndef NO_ASSERTIONS
    // register zero is never written back
    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        wb_en |-> (wb_addr != '0))
        else $error("writeback to register zero");

    // the clearing sweep runs once after reset
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_busy_reg |=> !clr_busy_reg)
        else $error("clearing sweep restarted");

    // a load-use hold needs a load still in flight ahead of writeback
    a_hazard_src: assert property (@(posedge clk) disable iff (!rst_n)
        hazard |-> (st_vld_reg[ST_MEM:0] != '0))
        else $error("operand hold with no load in flight");

    // a held instruction keeps its resolved operands
    a_hold_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !s1_move) |=> (byp_a_vld_reg && byp_b_vld_reg))
        else $error("held operands not refreshed");
`endif

endmodule

`default_nettype wire
